>>> rtl/iids_pkg.sv
// Shared types and constants for the indexed insert/delete stack.
package iids_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 5;
    localparam int CNT_OUT_W = 5;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;

    typedef enum logic [KIND_W-1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_INSERT = 2'd2,
        REQ_DELETE = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DEL_RD,
        ST_DEL_WAIT,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS_WR,
        ST_DEL_END,
        ST_TOP_RD,
        ST_TOP_WAIT,
        ST_DONE
    } t_state;

endpackage

>>> rtl/iids_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
module iids_ram #(
    parameter int WIDTH = iids_pkg::WORD_W,
    parameter int DEPTH = iids_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/indexed_insert_delete_stack.sv
// Indexed insert/delete stack: bounded stack in RAM with positional insert and delete.
// One request at a time. A refused request goes from its check straight to the top read;
// a push or insert shifts entries up (one read and one write each), then writes the word;
// a pop or delete reads the removed entry, shifts entries down, lowers the count; no top read if empty.
// The next request is taken the cycle after the result loads; a held result stalls it.
// Reset (synchronous, active low) empties the stack; RAM contents are not cleared.
module indexed_insert_delete_stack #(
    parameter int DEPTH = iids_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [31:0] write_value, [36:32] position, zero pad
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] req_type
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [31:0] removed_value, [63:32] top_value,
                                          // [68:64] entry_count, zero pad
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CW1  = CW + 1;
    localparam int CMPW = ((CW > iids_pkg::POS_W) ? CW : iids_pkg::POS_W) + 1;
    localparam int WW   = iids_pkg::WORD_W;

    // control state
    iids_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_o_valid, n_o_valid;

    // request and work registers
    iids_pkg::t_req    r_kind, n_kind;
    logic [WW-1:0]     r_word, n_word;
    logic [iids_pkg::POS_W-1:0] r_pos, n_pos;
    logic [AW-1:0]     r_slot, n_slot;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_ins, n_ins;
    iids_pkg::t_status r_status, n_status;
    logic [WW-1:0]     r_removed, n_removed;
    logic [WW-1:0]     r_top, n_top;

    // result registers
    iids_pkg::t_status r_o_status, n_o_status;
    logic [WW-1:0]     r_o_removed, n_o_removed;
    logic [WW-1:0]     r_o_top, n_o_top;
    logic [iids_pkg::CNT_OUT_W-1:0] r_o_count, n_o_count;

    // RAM port signals
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [WW-1:0] w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [WW-1:0] w_rd_data;

    logic              w_in_xfer;
    logic              w_out_free;
    iids_pkg::t_status w_status;
    logic [AW-1:0]     w_slot;
    logic              w_ins;
    logic              w_full;
    logic              w_empty;
    logic [CMPW-1:0]   w_pos_c;
    logic [CMPW-1:0]   w_cnt_c;
    logic [AW-1:0]     w_step;
    logic              w_more_ins;
    logic              w_more_del;
    logic              w_first_del;

    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_o_valid || i_m_axis_tready;

    // entry storage
    iids_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // classify the request and pick the target slot
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_pos_c = CMPW'(r_pos);
    assign w_cnt_c = CMPW'(r_count);

    always_comb begin
        w_status = iids_pkg::STAT_OK;
        w_slot   = '0;
        w_ins    = 1'b0;
        case (r_kind)
            iids_pkg::REQ_PUSH: begin
                w_ins  = 1'b1;
                w_slot = AW'(r_count);
                if (w_full) begin
                    w_status = iids_pkg::STAT_FULL;
                end
            end
            iids_pkg::REQ_POP: begin
                w_slot = AW'(r_count - 1'b1);
                if (w_empty) begin
                    w_status = iids_pkg::STAT_EMPTY;
                end
            end
            iids_pkg::REQ_INSERT: begin
                w_ins  = 1'b1;
                w_slot = AW'(r_pos - 1'b1);
                if (w_full) begin
                    w_status = iids_pkg::STAT_FULL;
                end else if (r_pos == '0 || w_pos_c > (w_cnt_c + 1'b1)) begin
                    w_status = iids_pkg::STAT_RANGE;
                end
            end
            default: begin
                w_slot = AW'(r_pos - 1'b1);
                if (w_empty) begin
                    w_status = iids_pkg::STAT_EMPTY;
                end else if (r_pos == '0 || w_pos_c > w_cnt_c) begin
                    w_status = iids_pkg::STAT_RANGE;
                end
            end
        endcase
    end

    // shared index stepper: down for insert, up for delete
    assign w_step      = r_ins ? (r_idx - 1'b1) : (r_idx + 1'b1);
    assign w_more_ins  = (w_step > r_slot);
    assign w_more_del  = ((CW1'(w_step) + 1'b1) < CW1'(r_count));
    assign w_first_del = ((CW1'(r_idx) + 1'b1) < CW1'(r_count));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            iids_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = iids_pkg::ST_CHECK;
                end
            end
            iids_pkg::ST_CHECK: begin
                if (w_status != iids_pkg::STAT_OK) begin
                    n_state = iids_pkg::ST_TOP_RD;
                end else if (w_ins) begin
                    n_state = (CW'(w_slot) < r_count) ? iids_pkg::ST_SH_RD
                                                       : iids_pkg::ST_INS_WR;
                end else begin
                    n_state = iids_pkg::ST_DEL_RD;
                end
            end
            iids_pkg::ST_DEL_RD:   n_state = iids_pkg::ST_DEL_WAIT;
            iids_pkg::ST_DEL_WAIT: begin
                n_state = w_first_del ? iids_pkg::ST_SH_RD : iids_pkg::ST_DEL_END;
            end
            iids_pkg::ST_SH_RD:    n_state = iids_pkg::ST_SH_WR;
            iids_pkg::ST_SH_WR: begin
                if (r_ins) begin
                    n_state = w_more_ins ? iids_pkg::ST_SH_RD : iids_pkg::ST_INS_WR;
                end else begin
                    n_state = w_more_del ? iids_pkg::ST_SH_RD : iids_pkg::ST_DEL_END;
                end
            end
            iids_pkg::ST_INS_WR:   n_state = iids_pkg::ST_TOP_RD;
            iids_pkg::ST_DEL_END:  n_state = iids_pkg::ST_TOP_RD;
            iids_pkg::ST_TOP_RD: begin
                n_state = w_empty ? iids_pkg::ST_DONE : iids_pkg::ST_TOP_WAIT;
            end
            iids_pkg::ST_TOP_WAIT: n_state = iids_pkg::ST_DONE;
            iids_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = iids_pkg::ST_IDLE;
                end
            end
            default:               n_state = iids_pkg::ST_IDLE;
        endcase
    end

    // datapath, RAM controls and result register loads
    always_comb begin
        n_count     = r_count;
        n_kind      = r_kind;
        n_word      = r_word;
        n_pos       = r_pos;
        n_slot      = r_slot;
        n_idx       = r_idx;
        n_ins       = r_ins;
        n_status    = r_status;
        n_removed   = r_removed;
        n_top       = r_top;
        n_o_valid   = r_o_valid;
        n_o_status  = r_o_status;
        n_o_removed = r_o_removed;
        n_o_top     = r_o_top;
        n_o_count   = r_o_count;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_idx;
        w_wr_data   = w_rd_data;
        w_rd_en     = 1'b0;
        w_rd_addr   = w_step;

        // drop a delivered result
        if (r_o_valid && i_m_axis_tready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            iids_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_kind    = iids_pkg::t_req'(i_s_axis_tuser[1:0]);
                    n_word    = i_s_axis_tdata[31:0];
                    n_pos     = i_s_axis_tdata[36:32];
                    n_removed = '0;
                end
            end
            iids_pkg::ST_CHECK: begin
                n_status = w_status;
                n_slot   = w_slot;
                n_ins    = w_ins;
                n_idx    = w_ins ? AW'(r_count) : w_slot;
            end
            iids_pkg::ST_DEL_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_slot;
            end
            iids_pkg::ST_DEL_WAIT: begin
                n_removed = w_rd_data;
            end
            iids_pkg::ST_SH_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_step;
            end
            iids_pkg::ST_SH_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx;
                w_wr_data = w_rd_data;
                n_idx     = w_step;
            end
            iids_pkg::ST_INS_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_slot;
                w_wr_data = r_word;
                n_count   = r_count + 1'b1;
            end
            iids_pkg::ST_DEL_END: begin
                n_count = r_count - 1'b1;
            end
            iids_pkg::ST_TOP_RD: begin
                if (w_empty) begin
                    n_top = '0;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(r_count - 1'b1);
                end
            end
            iids_pkg::ST_TOP_WAIT: begin
                n_top = w_rd_data;
            end
            iids_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_status  = r_status;
                    n_o_removed = r_removed;
                    n_o_top     = r_top;
                    n_o_count   = iids_pkg::CNT_OUT_W'(r_count);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= iids_pkg::ST_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_word      <= n_word;
        r_pos       <= n_pos;
        r_slot      <= n_slot;
        r_idx       <= n_idx;
        r_ins       <= n_ins;
        r_status    <= n_status;
        r_removed   <= n_removed;
        r_top       <= n_top;
        r_o_status  <= n_o_status;
        r_o_removed <= n_o_removed;
        r_o_top     <= n_o_top;
        r_o_count   <= n_o_count;
    end

    // ports
    assign o_s_axis_tready = (r_state == iids_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tuser  = r_o_status;
    assign o_m_axis_tdata  = {3'b000, r_o_count, r_o_top, r_o_removed};

    // the count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    // an accepted request always starts its check in the next cycle
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == iids_pkg::ST_CHECK))
        else $error("accepted request did not enter check");

    // the count moves by at most one per request
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + 1'b1) || (r_count == $past(r_count) - 1'b1)))
        else $error("entry count jumped");

    // no RAM write while idle or reporting
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == iids_pkg::ST_IDLE) || (r_state == iids_pkg::ST_DONE)) |-> !w_wr_en)
        else $error("RAM write outside a request");

endmodule
